FILE: hw/rtl/ple_pkg.sv
// shared types and constants of the positional list engine
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 5;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_START = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_START = 3'd3,
    ACT_DEL_END   = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_RD_FWD    = 3'd6,
    ACT_RD_BWD    = 3'd7
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } stat_t;

  // what every cell does this cycle
  typedef enum logic [2:0] {
    CM_HOLD    = 3'd0,
    CM_INSERT  = 3'd1,
    CM_DELETE  = 3'd2,
    CM_ROT_FWD = 3'd3,
    CM_ROT_BWD = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] bus_val;
  } cell_ctl_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_cell.sv
// one list cell: holds a value and takes from its neighbors or the bus
`default_nettype none

module ple_cell (
  input  wire logic                      clk,
  input  wire logic [ple_pkg::IDX_W-1:0] cell_idx,
  input  wire ple_pkg::cell_ctl_t        ctl,
  input  wire logic [ple_pkg::VAL_W-1:0] prev_val,
  input  wire logic [ple_pkg::VAL_W-1:0] next_val,
  output logic      [ple_pkg::VAL_W-1:0] val
);

  logic [ple_pkg::VAL_W-1:0] val_r;
  logic [ple_pkg::VAL_W-1:0] val_nxt;
  logic [ple_pkg::CNT_W-1:0] my_pos;
  logic [ple_pkg::CNT_W-1:0] my_pos_p1;

  assign my_pos    = ple_pkg::CNT_W'(cell_idx);
  assign my_pos_p1 = my_pos + ple_pkg::CNT_W'(1);

  always_comb begin
    val_nxt = val_r;
    case (ctl.mode)
      ple_pkg::CM_INSERT: begin
        if (cell_idx == ctl.idx) begin
          val_nxt = ctl.bus_val;
        end else if (cell_idx > ctl.idx && my_pos <= ctl.cnt) begin
          val_nxt = prev_val;
        end
      end
      ple_pkg::CM_DELETE: begin
        if (cell_idx >= ctl.idx && my_pos_p1 < ctl.cnt) begin
          val_nxt = next_val;
        end
      end
      ple_pkg::CM_ROT_FWD: begin
        if (my_pos_p1 == ctl.cnt) begin
          val_nxt = ctl.bus_val;
        end else if (my_pos < ctl.cnt) begin
          val_nxt = next_val;
        end
      end
      ple_pkg::CM_ROT_BWD: begin
        if (my_pos == '0) begin
          val_nxt = ctl.bus_val;
        end else if (my_pos < ctl.cnt) begin
          val_nxt = prev_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ple_cell_row.sv
// row of list cells with head and tail taps
`default_nettype none

module ple_cell_row (
  input  wire logic                      clk,
  input  wire ple_pkg::cell_ctl_t        ctl,
  output logic      [ple_pkg::VAL_W-1:0] head_val,
  output logic      [ple_pkg::VAL_W-1:0] tail_val
);

  logic [ple_pkg::VAL_W-1:0] vals [ple_pkg::CAPACITY];
  logic [ple_pkg::CNT_W-1:0] tail_pos;

  for (genvar g = 0; g < ple_pkg::CAPACITY; g++) begin : g_cell
    logic [ple_pkg::VAL_W-1:0] prev_v;
    logic [ple_pkg::VAL_W-1:0] next_v;

    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = vals[g-1];
    end

    if (g == ple_pkg::CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_n
      assign next_v = vals[g+1];
    end

    ple_cell u_cell (
      .clk      (clk),
      .cell_idx (ple_pkg::IDX_W'(g)),
      .ctl      (ctl),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (vals[g])
    );
  end

  // tail tap is only meaningful with a non-empty list
  assign tail_pos = ctl.cnt - ple_pkg::CNT_W'(1);
  assign head_val = vals[0];
  assign tail_val = vals[tail_pos[ple_pkg::IDX_W-1:0]];

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// top level of the positional list engine
// Ordered list of up to ple_pkg::CAPACITY signed 32-bit values in a row of
// cells, entry 0 at the front. Every edit (insert or delete at start, end or
// 1-based position) is applied on acceptance: the cells from the edit point on
// shift toward or away from it at once, and one result transaction follows
// with status and new length. A read (forward or backward) first enters the
// read state and then emits the entries one at a time while the result
// register is free: the row rotates one place per emitted value, so after
// the read the list is back in place; it emits length transactions, the
// final one marked last, or a single empty-status transaction for an empty
// list. New input is taken only between actions, so a read blocks the input
// until its last entry is emitted; a stalled result stretches this further.
// The result register lets a new edit enter in the cycle its predecessor's
// result is taken. Cell contents need no reset.
`default_nettype none

module positional_list_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ple_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ple_pkg::out_item_t     out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [ple_pkg::CNT_W-1:0] count_r;
  logic [ple_pkg::CNT_W-1:0] count_nxt;
  logic [ple_pkg::CNT_W-1:0] rd_left_r;
  logic [ple_pkg::CNT_W-1:0] rd_left_nxt;
  logic                      rd_bwd_r;
  logic                      rd_bwd_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  ple_pkg::out_item_t        out_data_r;
  ple_pkg::out_item_t        out_data_nxt;

  ple_pkg::cell_ctl_t        ctl;
  logic [ple_pkg::VAL_W-1:0] head_val;
  logic [ple_pkg::VAL_W-1:0] tail_val;

  logic                      slot_free;
  logic                      accept;
  logic                      full;
  logic [ple_pkg::POS_W-1:0] pos;
  logic [ple_pkg::POS_W-1:0] cnt_ext;
  logic [ple_pkg::POS_W-1:0] ins_raw;
  logic [ple_pkg::POS_W-1:0] ins_idx;
  logic [ple_pkg::POS_W-1:0] del_idx;

  // result register frees up in the cycle its transaction is taken
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  assign full    = (count_r == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign pos     = in_data.position;
  assign cnt_ext = ple_pkg::POS_W'(count_r);

  // insert position: one goes first, zero acts like two, past end appends
  always_comb begin
    if (pos == ple_pkg::POS_W'(1)) begin
      ins_raw = '0;
    end else if (pos == '0) begin
      ins_raw = ple_pkg::POS_W'(1);
    end else begin
      ins_raw = pos - ple_pkg::POS_W'(1);
    end
    ins_idx = (ins_raw > cnt_ext) ? cnt_ext : ins_raw;
    // delete position zero acts like one
    del_idx = (pos == '0) ? '0 : (pos - ple_pkg::POS_W'(1));
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_left_nxt   = rd_left_r;
    rd_bwd_nxt    = rd_bwd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    ctl.mode    = ple_pkg::CM_HOLD;
    ctl.idx     = '0;
    ctl.cnt     = count_r;
    ctl.bus_val = in_data.item_value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // edits give one result; fill in the common part here
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = '0;
          out_data_nxt.status     = ple_pkg::ST_OK;
          out_data_nxt.last       = 1'b1;
          case (ple_pkg::act_t'(in_data.action))
            ple_pkg::ACT_INS_START,
            ple_pkg::ACT_INS_END,
            ple_pkg::ACT_INS_POS: begin
              if (full) begin
                out_data_nxt.status = ple_pkg::ST_FULL;
              end else begin
                ctl.mode = ple_pkg::CM_INSERT;
                case (ple_pkg::act_t'(in_data.action))
                  ple_pkg::ACT_INS_START: ctl.idx = '0;
                  ple_pkg::ACT_INS_END:   ctl.idx = count_r[ple_pkg::IDX_W-1:0];
                  default:                ctl.idx = ins_idx[ple_pkg::IDX_W-1:0];
                endcase
                count_nxt = count_r + ple_pkg::CNT_W'(1);
              end
            end
            ple_pkg::ACT_DEL_START,
            ple_pkg::ACT_DEL_END,
            ple_pkg::ACT_DEL_POS: begin
              if (count_r == '0) begin
                out_data_nxt.status = ple_pkg::ST_EMPTY;
              end else if (ple_pkg::act_t'(in_data.action) == ple_pkg::ACT_DEL_POS
                           && del_idx >= cnt_ext) begin
                out_data_nxt.status = ple_pkg::ST_BADPOS;
              end else begin
                ctl.mode = ple_pkg::CM_DELETE;
                case (ple_pkg::act_t'(in_data.action))
                  ple_pkg::ACT_DEL_START: ctl.idx = '0;
                  ple_pkg::ACT_DEL_END: begin
                    ctl.idx = ple_pkg::IDX_W'(count_r - ple_pkg::CNT_W'(1));
                  end
                  default: ctl.idx = del_idx[ple_pkg::IDX_W-1:0];
                endcase
                count_nxt = count_r - ple_pkg::CNT_W'(1);
              end
            end
            default: begin
              // reads: empty list answers at once, otherwise walk the row
              if (count_r == '0) begin
                out_data_nxt.status = ple_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                rd_left_nxt   = count_r;
                rd_bwd_nxt    = (ple_pkg::act_t'(in_data.action) == ple_pkg::ACT_RD_BWD);
              end
            end
          endcase
          out_data_nxt.length = ple_pkg::LEN_W'(count_nxt);
        end
      end
      S_READ: begin
        if (slot_free) begin
          // emit the end entry and rotate it around to the other end
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = rd_bwd_r ? tail_val : head_val;
          out_data_nxt.status     = ple_pkg::ST_OK;
          out_data_nxt.last       = (rd_left_r == ple_pkg::CNT_W'(1));
          out_data_nxt.length     = ple_pkg::LEN_W'(count_r);
          ctl.mode    = rd_bwd_r ? ple_pkg::CM_ROT_BWD : ple_pkg::CM_ROT_FWD;
          ctl.bus_val = rd_bwd_r ? tail_val : head_val;
          rd_left_nxt = rd_left_r - ple_pkg::CNT_W'(1);
          if (rd_left_r == ple_pkg::CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  ple_cell_row u_row (
    .clk      (clk),
    .ctl      (ctl),
    .head_val (head_val),
    .tail_val (tail_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_left_r   <= '0;
      rd_bwd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_bwd_r    <= rd_bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count above capacity");

  // a running read always has entries left to emit, no more than the list holds
  a_read_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (rd_left_r != '0 && rd_left_r <= count_r))
    else $error("read counter out of range");

  // the length only moves on an accepted transaction
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("entry count changed without input");

  // emitting the final entry of a read returns to idle
  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && slot_free && rd_left_r == ple_pkg::CNT_W'(1))
    |=> (state_r == S_IDLE && out_valid_r && out_data_r.last))
    else $error("read did not finish on its last entry");

endmodule

`default_nettype wire

FILE: dv/positional_list_engine_chk.sv
// checker for the positional list engine: tracks the list, predicts results, compares
`timescale 1ns / 100ps

module positional_list_engine_chk
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        pending,
  output int        held_count
);

  logic signed [VAL_W-1:0] entries_q[$];
  out_item_t               results_due_q[$];
  out_item_t               want;
  int                      err_count = 0;

  assign errors     = err_count;
  assign pending    = results_due_q.size();
  assign held_count = entries_q.size();

  function automatic stat_t insert_entry(int idx, logic signed [VAL_W-1:0] value);
    if (entries_q.size() >= CAPACITY) return ST_FULL;
    if (idx > entries_q.size()) idx = entries_q.size();
    entries_q.insert(idx, value);
    return ST_OK;
  endfunction

  function automatic stat_t remove_entry(int idx);
    if (entries_q.size() == 0) return ST_EMPTY;
    if (idx >= entries_q.size()) return ST_BADPOS;
    entries_q.delete(idx);
    return ST_OK;
  endfunction

  function automatic void push_result(logic signed [VAL_W-1:0] value, stat_t st,
                                      logic is_last);
    out_item_t r;
    r.read_value = value;
    r.status     = st;
    r.last       = is_last;
    r.length     = LEN_W'(entries_q.size());
    results_due_q.push_back(r);
  endfunction

  // applies one list action and queues the results it should produce
  function automatic void apply_list_action(in_item_t it);
    stat_t st;
    int    idx;
    int    n;
    st = ST_OK;
    case (act_t'(it.action))
      ACT_INS_START: st = insert_entry(0, it.item_value);
      ACT_INS_END:   st = insert_entry(entries_q.size(), it.item_value);
      ACT_INS_POS: begin
        // position zero lands after the first entry
        if (it.position == 1) idx = 0;
        else if (it.position == 0) idx = 1;
        else idx = int'(it.position) - 1;
        st = insert_entry(idx, it.item_value);
      end
      ACT_DEL_START: st = remove_entry(0);
      ACT_DEL_END: begin
        if (entries_q.size() == 0) st = ST_EMPTY;
        else st = remove_entry(entries_q.size() - 1);
      end
      ACT_DEL_POS: begin
        idx = (it.position == 0) ? 0 : int'(it.position) - 1;
        st = remove_entry(idx);
      end
      default: begin
        n = entries_q.size();
        if (n == 0) begin
          push_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            push_result((act_t'(it.action) == ACT_RD_FWD) ? entries_q[i] : entries_q[n - 1 - i],
                        ST_OK, (i == n - 1));
          end
        end
        return;
      end
    endcase
    push_result('0, st, 1'b1);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // results first: an action taken at this edge cannot answer at the same edge
      if (out_valid && out_ready) begin
        if (results_due_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result value=%0d status=%0d last=%0b length=%0d",
                   $time, out_data.read_value, out_data.status, out_data.last,
                   out_data.length);
        end else begin
          want = results_due_q.pop_front();
          if (out_data.read_value !== want.read_value || out_data.status !== want.status ||
              out_data.last !== want.last || out_data.length !== want.length) begin
            err_count++;
            $display("%0t: mismatch exp value=%0d status=%0d last=%0b length=%0d, %s",
                     $time, want.read_value, want.status, want.last, want.length,
                     $sformatf("got value=%0d status=%0d last=%0b length=%0d",
                               out_data.read_value, out_data.status, out_data.last,
                               out_data.length));
          end
        end
      end
      if (in_valid && in_ready) apply_list_action(in_data);
    end
  end

endmodule

FILE: dv/positional_list_engine_tb.sv
// testbench top for the positional list engine: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int errors;
  int pending;
  int held_count;
  int cycle_count = 0;

  // while set, neither side inserts bubbles
  logic no_idle = 1'b0;

  positional_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  positional_list_engine_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (errors),
    .pending    (pending),
    .held_count (held_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_list_engine_tb NOT OK");
      $finish;
    end
  end

  // bubble length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly full-range random, with the sign and magnitude extremes mixed in
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction at the falling edge and hold it until the block takes it,
  // then optionally drop valid for a random gap
  task automatic send_action(act_t act, logic signed [VAL_W-1:0] value, logic [POS_W-1:0] pos);
    int          gap;
    logic [63:0] junk;
    @(negedge clk);
    in_valid           = 1'b1;
    in_data.action     = act;
    in_data.item_value = value;
    in_data.position   = pos;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      junk     = {$urandom, $urandom};
      in_data  = junk[$bits(in_item_t)-1:0];
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // result side back-pressure, changed at the falling edge only
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle || $urandom_range(0, 99) >= 25) begin
        out_ready = 1'b1;
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic             growing;
    int               r;
    int               cnt;
    act_t             act;
    logic [POS_W-1:0] pos;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list: reads and every delete kind report empty
    send_action(ACT_RD_FWD, '0, 8'd1);
    send_action(ACT_RD_BWD, '0, 8'd1);
    send_action(ACT_DEL_START, '0, 8'd1);
    send_action(ACT_DEL_END, '0, 8'd1);
    send_action(ACT_DEL_POS, '0, 8'd0);
    send_action(ACT_DEL_POS, '0, 8'd255);

    // first insert into an empty list, positional with position zero
    send_action(ACT_INS_POS, 32'sh7fff_ffff, 8'd0);
    send_action(ACT_INS_START, 32'sh8000_0000, 8'd1);
    send_action(ACT_INS_END, 32'sh5555_aaaa, 8'd1);
    // position zero goes after the first entry
    send_action(ACT_INS_POS, -32'sd1, 8'd0);
    // position far past the end appends
    send_action(ACT_INS_POS, 32'sh0f0f_f0f0, 8'd255);
    send_action(ACT_INS_POS, 32'sh1234_5678, 8'd1);

    // fill up to capacity, then one insert that must be refused as full
    for (int i = 6; i < CAPACITY; i++) send_action(ACT_INS_END, $urandom, 8'd1);
    send_action(ACT_INS_START, 32'sh2aaa_aaaa, 8'd1);
    send_action(ACT_RD_FWD, '0, 8'd1);

    // delete past the end, at position zero, in the middle, at both ends
    send_action(ACT_DEL_POS, '0, 8'd255);
    send_action(ACT_DEL_POS, '0, 8'd0);
    send_action(ACT_DEL_POS, '0, 8'd2);
    send_action(ACT_DEL_END, '0, 8'd1);
    send_action(ACT_DEL_START, '0, 8'd1);
    send_action(ACT_RD_BWD, '0, 8'd1);

    // random part: alternate between growing and shrinking runs so the list
    // swings between empty and full, with reads sprinkled throughout
    growing = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i % 60) < 12);
      cnt     = held_count;
      if (growing && cnt >= CAPACITY && $urandom_range(0, 1)) growing = 1'b0;
      if (!growing && cnt == 0 && $urandom_range(0, 1)) growing = 1'b1;

      r = $urandom_range(0, 99);
      if ((growing && r < 60) || (!growing && r >= 60 && r < 80)) begin
        case ($urandom_range(0, 2))
          0:       act = ACT_INS_START;
          1:       act = ACT_INS_END;
          default: act = ACT_INS_POS;
        endcase
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0:       act = ACT_DEL_START;
          1:       act = ACT_DEL_END;
          default: act = ACT_DEL_POS;
        endcase
      end else begin
        act = $urandom_range(0, 1) ? ACT_RD_FWD : ACT_RD_BWD;
      end

      // positions mostly around the live range, sometimes anywhere in the field
      if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, cnt + 2));
      else pos = POS_W'($urandom_range(0, 255));

      send_action(act, pick_value(), pos);
    end

    @(negedge clk);
    in_valid = 1'b0;

    // let every outstanding result drain, then give the block a little extra time
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("positional_list_engine_tb OK");
    end else begin
      $display("positional_list_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_cell_row.sv
hw/rtl/positional_list_engine.sv
dv/positional_list_engine_chk.sv
dv/positional_list_engine_tb.sv
